>>> src/lmbcm_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix BCM scan driver package
// Shared request, result, configuration and sequencer control types.
// ----------------------------------------------------------------------------
package lmbcm_pkg;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam int unsigned CFG_ADDR_W = 5;

  localparam logic [2:0] REG_RUN_ENABLE       = 3'd0;
  localparam logic [2:0] REG_BASE_TICKS       = 3'd1;
  localparam logic [2:0] REG_PLANES_IN_USE    = 3'd2;
  localparam logic [2:0] REG_COLUMNS_IN_USE   = 3'd3;
  localparam logic [2:0] REG_ROW_PAIRS_IN_USE = 3'd4;

  localparam logic [15:0] RESET_BASE_TICKS       = 16'd100;
  localparam logic [3:0]  RESET_PLANES_IN_USE    = 4'd11;
  localparam logic [6:0]  RESET_COLUMNS_IN_USE   = 7'd32;
  localparam logic [4:0]  RESET_ROW_PAIRS_IN_USE = 5'd16;

  localparam int unsigned BASE_W = 16;

  typedef enum logic [2:0] {
    PH_ROW,
    PH_DATA,
    PH_CLKHI,
    PH_CLEAR,
    PH_LATCH_HI,
    PH_LATCH_LO,
    PH_LIT,
    PH_DARK
  } phase_e;

  typedef enum logic [1:0] {
    DOP_HOLD,
    DOP_LOAD,
    DOP_CLEAR
  } data_op_e;

  typedef struct packed {
    logic       cmd;
    logic [3:0] row_pair;
    logic [5:0] column;
    logic [3:0] plane;
    logic [5:0] colour_bits;
  } in_req_t;

  typedef struct packed {
    logic [2:0] upper_rgb;
    logic [2:0] lower_rgb;
    logic       shift_clock;
    logic       latch;
    logic       output_enable_n;
    logic [3:0] row_select;
  } out_res_t;

  typedef struct packed {
    logic        run_enable;
    logic [15:0] base_ticks;
    logic [3:0]  planes_in_use;
    logic [6:0]  columns_in_use;
    logic [4:0]  row_pairs_in_use;
  } cfg_t;

  typedef struct packed {
    data_op_e   dop;
    logic       shift_clock;
    logic       latch;
    logic       output_enable_n;
    logic [3:0] row_select;
  } seq_ctl_t;

endpackage

>>> src/lmbcm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lmbcm_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 11264,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lmbcm_cfg.sv
// ----------------------------------------------------------------------------
// LED matrix BCM configuration registers
// APB-style register file for run control, lit time and scan extents.
// ----------------------------------------------------------------------------
module lmbcm_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lmbcm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output lmbcm_pkg::cfg_t                 cfg_o
);

  import lmbcm_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_RUN_ENABLE:       cfg_d.run_enable       = pwdata[0];
        REG_BASE_TICKS:       cfg_d.base_ticks       = pwdata[15:0];
        REG_PLANES_IN_USE:    cfg_d.planes_in_use    = pwdata[3:0];
        REG_COLUMNS_IN_USE:   cfg_d.columns_in_use   = pwdata[6:0];
        REG_ROW_PAIRS_IN_USE: cfg_d.row_pairs_in_use = pwdata[4:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_enable       <= 1'b0;
      cfg_q.base_ticks       <= RESET_BASE_TICKS;
      cfg_q.planes_in_use    <= RESET_PLANES_IN_USE;
      cfg_q.columns_in_use   <= RESET_COLUMNS_IN_USE;
      cfg_q.row_pairs_in_use <= RESET_ROW_PAIRS_IN_USE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_RUN_ENABLE:       prdata = {31'd0, cfg_q.run_enable};
      REG_BASE_TICKS:       prdata = {16'd0, cfg_q.base_ticks};
      REG_PLANES_IN_USE:    prdata = {28'd0, cfg_q.planes_in_use};
      REG_COLUMNS_IN_USE:   prdata = {25'd0, cfg_q.columns_in_use};
      REG_ROW_PAIRS_IN_USE: prdata = {27'd0, cfg_q.row_pairs_in_use};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/lmbcm_seq.sv
// ----------------------------------------------------------------------------
// LED matrix BCM scan sequencer
// Row, plane and column counters, lit timer and control pin state.
// ----------------------------------------------------------------------------
module lmbcm_seq #(
  parameter int unsigned MAX_PLANES    = 11,
  parameter int unsigned MAX_COLUMNS   = 64,
  parameter int unsigned MAX_ROW_PAIRS = 16,
  parameter int unsigned PLANE_OFFSET  = 0,
  parameter int unsigned AW            = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lmbcm_pkg::cfg_t     cfg_i,
  input  logic                adv_i,
  output lmbcm_pkg::seq_ctl_t ctl_o,
  output logic [AW-1:0]       rd_addr_o
);

  import lmbcm_pkg::*;

  localparam int unsigned PW = $clog2(MAX_PLANES + 1);
  localparam int unsigned CW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RW = $clog2(MAX_ROW_PAIRS + 1);
  localparam int unsigned TW = BASE_W + MAX_PLANES - 1;
  localparam int unsigned RESET_N = (MAX_PLANES < 11) ? MAX_PLANES : 11;
  localparam int unsigned FP_RAW = PLANE_OFFSET + MAX_PLANES - RESET_N;
  localparam int unsigned RESET_FIRST = (FP_RAW > MAX_PLANES - 1) ? MAX_PLANES - 1 : FP_RAW;

  phase_e        phase_q, phase_d;
  logic [RW-1:0] row_q, row_d;
  logic [PW-1:0] plane_q, plane_d;
  logic [CW-1:0] col_q, col_d;
  logic [TW-1:0] timer_q, timer_d;
  logic          clk_q, clk_d;
  logic          lat_q, lat_d;
  logic          oe_n_q, oe_n_d;
  logic [3:0]    rowaddr_q, rowaddr_d;
  data_op_e      dop;
  logic          advance;
  logic [8:0]    cols_lim;
  logic [5:0]    rows_lim;
  logic [4:0]    planes_lim;
  logic [5:0]    first_raw;
  logic [PW-1:0] first_plane;
  logic [15:0]   base_eff;
  logic [TW-1:0] lit_len;
  logic [TW-1:0] timer_inc;
  logic [CW-1:0] col_inc;
  logic [RW-1:0] row_inc;
  logic [PW-1:0] plane_inc;
  logic [RW+3:0] row_ext;

  assign advance = adv_i && cfg_i.run_enable;

  always_comb begin
    cols_lim = {2'b00, cfg_i.columns_in_use};
    if (cols_lim == 9'd0) begin
      cols_lim = 9'd1;
    end else if (cols_lim > 9'(MAX_COLUMNS)) begin
      cols_lim = 9'(MAX_COLUMNS);
    end
    rows_lim = {1'b0, cfg_i.row_pairs_in_use};
    if (rows_lim == 6'd0) begin
      rows_lim = 6'd1;
    end else if (rows_lim > 6'(MAX_ROW_PAIRS)) begin
      rows_lim = 6'(MAX_ROW_PAIRS);
    end
    planes_lim = {1'b0, cfg_i.planes_in_use};
    if (planes_lim == 5'd0) begin
      planes_lim = 5'd1;
    end else if (planes_lim > 5'(MAX_PLANES)) begin
      planes_lim = 5'(MAX_PLANES);
    end
    first_raw = 6'(PLANE_OFFSET) + 6'(MAX_PLANES) - {1'b0, planes_lim};
    if (first_raw > 6'(MAX_PLANES - 1)) begin
      first_raw = 6'(MAX_PLANES - 1);
    end
    first_plane = PW'(first_raw);
  end

  assign base_eff  = (cfg_i.base_ticks == 16'd0) ? 16'd1 : cfg_i.base_ticks;
  assign lit_len   = TW'(base_eff) << plane_q;
  assign timer_inc = timer_q + 1'b1;
  assign col_inc   = col_q + 1'b1;
  assign row_inc   = row_q + 1'b1;
  assign plane_inc = plane_q + 1'b1;
  assign row_ext   = {4'd0, row_q};

  always_comb begin
    phase_d   = phase_q;
    row_d     = row_q;
    plane_d   = plane_q;
    col_d     = col_q;
    timer_d   = timer_q;
    clk_d     = clk_q;
    lat_d     = lat_q;
    oe_n_d    = oe_n_q;
    rowaddr_d = rowaddr_q;
    dop       = DOP_HOLD;
    if (advance) begin
      case (phase_q)
        PH_ROW: begin
          rowaddr_d = row_ext[3:0];
          plane_d   = first_plane;
          col_d     = '0;
          phase_d   = PH_DATA;
        end
        PH_DATA: begin
          clk_d   = 1'b0;
          dop     = DOP_LOAD;
          phase_d = PH_CLKHI;
        end
        PH_CLKHI: begin
          clk_d   = 1'b1;
          col_d   = col_inc;
          phase_d = (9'(col_inc) >= cols_lim) ? PH_CLEAR : PH_DATA;
        end
        PH_CLEAR: begin
          clk_d   = 1'b0;
          dop     = DOP_CLEAR;
          phase_d = PH_LATCH_HI;
        end
        PH_LATCH_HI: begin
          lat_d   = 1'b1;
          phase_d = PH_LATCH_LO;
        end
        PH_LATCH_LO: begin
          lat_d   = 1'b0;
          timer_d = '0;
          phase_d = PH_LIT;
        end
        PH_LIT: begin
          oe_n_d = 1'b0;
          if (timer_inc >= lit_len) begin
            timer_d = '0;
            phase_d = PH_DARK;
          end else begin
            timer_d = timer_inc;
          end
        end
        PH_DARK: begin
          oe_n_d  = 1'b1;
          plane_d = plane_inc;
          if (plane_inc < PW'(MAX_PLANES)) begin
            col_d   = '0;
            phase_d = PH_DATA;
          end else begin
            row_d   = (6'(row_inc) >= rows_lim) ? '0 : row_inc;
            phase_d = PH_ROW;
          end
        end
        default: phase_d = PH_ROW;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_ROW;
      row_q     <= '0;
      plane_q   <= PW'(RESET_FIRST);
      col_q     <= '0;
      timer_q   <= '0;
      clk_q     <= 1'b0;
      lat_q     <= 1'b0;
      oe_n_q    <= 1'b1;
      rowaddr_q <= 4'd0;
    end else begin
      phase_q   <= phase_d;
      row_q     <= row_d;
      plane_q   <= plane_d;
      col_q     <= col_d;
      timer_q   <= timer_d;
      clk_q     <= clk_d;
      lat_q     <= lat_d;
      oe_n_q    <= oe_n_d;
      rowaddr_q <= rowaddr_d;
    end
  end

  assign ctl_o.dop             = dop;
  assign ctl_o.shift_clock     = clk_d;
  assign ctl_o.latch           = lat_d;
  assign ctl_o.output_enable_n = oe_n_d;
  assign ctl_o.row_select      = rowaddr_d;

  assign rd_addr_o = AW'((32'(row_q) * MAX_COLUMNS + 32'(col_q)) * MAX_PLANES
                         + 32'(plane_q));

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> (plane_q < PW'(MAX_PLANES)) && (col_q < CW'(MAX_COLUMNS)))
    else $error("Store read address out of range.");

  a_latch_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && phase_q == PH_LATCH_HI |=> lat_q && phase_q == PH_LATCH_LO)
    else $error("Latch pulse did not start.");

  a_lit_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && phase_q == PH_LIT |=> !oe_n_q)
    else $error("Output enable not asserted while lit.");

endmodule

>>> src/led_matrix_bcm_scan_driver_top.sv
// ----------------------------------------------------------------------------
// LED matrix BCM scan driver
// Top level: request channel, bitplane store, scan sequencer, pin output.
// ----------------------------------------------------------------------------
// Each request is either a store write or a tick. A write puts six colour
// bits into the bitplane store if in range and gives no result. A tick
// advances the scan by one pin update while run is enabled and gives
// exactly one result with the full pin state, passed through the store
// read stage and the output register. One request is accepted every cycle
// while the output is not stalled; the single read port of the store
// serves the column data of one tick per cycle while writes use the write
// port. When the receiver stalls, the output register holds its result and
// the stage behind it still takes one tick; further requests are stalled
// until the output drains. Reset clears the sequencer and pins (output
// enable high, all else low) and loads the configuration reset values. The
// store is not cleared and must be written before it is shown. The user
// must write configuration via APB with no request in flight (unenforced).
// ----------------------------------------------------------------------------
module led_matrix_bcm_scan_driver_top #(
  parameter int unsigned MAX_PLANES    = 11,
  parameter int unsigned MAX_COLUMNS   = 64,
  parameter int unsigned MAX_ROW_PAIRS = 16,
  parameter int unsigned PLANE_OFFSET  = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lmbcm_pkg::in_req_t               in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lmbcm_pkg::out_res_t              out_res_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lmbcm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  import lmbcm_pkg::*;

  localparam int unsigned DEPTH = MAX_ROW_PAIRS * MAX_COLUMNS * MAX_PLANES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t          cfg;
  seq_ctl_t      ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [5:0]    rd_data;
  logic          in_acc;
  logic          tick_acc;
  logic          wr_in_range;
  logic          ram_we;
  logic          ram_re;
  logic          out_free;
  logic          s1_move;
  logic          s1_valid_q, s1_valid_d;
  seq_ctl_t      s1_ctl_q;
  logic          out_valid_q, out_valid_d;
  out_res_t      out_q, out_d;
  logic [5:0]    data_next;

  lmbcm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lmbcm_seq #(
    .MAX_PLANES    (MAX_PLANES),
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROW_PAIRS (MAX_ROW_PAIRS),
    .PLANE_OFFSET  (PLANE_OFFSET),
    .AW            (AW)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .adv_i     (tick_acc),
    .ctl_o     (ctl),
    .rd_addr_o (rd_addr)
  );

  lmbcm_ram #(
    .WIDTH (6),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (in_req_i.colour_bits),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (in_req_i.cmd == CMD_TICK);

  assign wr_in_range = (32'(in_req_i.row_pair) < MAX_ROW_PAIRS)
                    && (32'(in_req_i.column) < MAX_COLUMNS)
                    && (32'(in_req_i.plane) < MAX_PLANES);
  assign ram_we  = in_acc && (in_req_i.cmd == CMD_WRITE) && wr_in_range;
  assign wr_addr = AW'((32'(in_req_i.row_pair) * MAX_COLUMNS + 32'(in_req_i.column))
                       * MAX_PLANES + 32'(in_req_i.plane));
  assign ram_re  = tick_acc && (ctl.dop == DOP_LOAD);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (tick_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    case (s1_ctl_q.dop)
      DOP_LOAD:  data_next = rd_data;
      DOP_CLEAR: data_next = 6'd0;
      default:   data_next = {out_q.lower_rgb, out_q.upper_rgb};
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d           = 1'b1;
      out_d.upper_rgb       = data_next[2:0];
      out_d.lower_rgb       = data_next[5:3];
      out_d.shift_clock     = s1_ctl_q.shift_clock;
      out_d.latch           = s1_ctl_q.latch;
      out_d.output_enable_n = s1_ctl_q.output_enable_n;
      out_d.row_select      = s1_ctl_q.row_select;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
      out_q.upper_rgb       <= 3'd0;
      out_q.lower_rgb       <= 3'd0;
      out_q.shift_clock     <= 1'b0;
      out_q.latch           <= 1'b0;
      out_q.output_enable_n <= 1'b1;
      out_q.row_select      <= 4'd0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_ctl_q <= ctl;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  a_single_port_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("Store written and read by the same request.");

  a_tick_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> s1_valid_q)
    else $error("Accepted tick lost before the output stage.");

endmodule

>>> tb/sv/led_matrix_bcm_scan_driver_top_tb.sv
// ----------------------------------------------------------------------------
// LED matrix BCM scan driver testbench
// Preloads the bitplane store, then sends tick and store write requests
// under several register settings. Every pin state is checked against a
// cycle-free scan sequencer kept alongside the block.
// ----------------------------------------------------------------------------
module led_matrix_bcm_scan_driver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lmbcm_pkg::*;

  localparam int unsigned N_PLANES     = 11;
  localparam int unsigned N_COLUMNS    = 64;
  localparam int unsigned N_ROW_PAIRS  = 16;
  localparam int unsigned IDLE_PCT     = 8;
  localparam int unsigned WRITE_PCT    = 12;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_req_t               in_req_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_res_t              out_res_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr       = '0;
  logic [31:0]           pwdata      = '0;
  logic [31:0]           prdata;
  logic                  pready;

  in_req_t     pending[$];
  out_res_t    pins_due[$];
  logic        in_taken    = 1'b0;
  bit          steady      = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;
  int unsigned hold_left   = 0;
  int unsigned errors      = 0;

  cfg_t            cfg_q     = '{1'b0, RESET_BASE_TICKS, RESET_PLANES_IN_USE,
                                 RESET_COLUMNS_IN_USE, RESET_ROW_PAIRS_IN_USE};
  logic [5:0]      plane_mem [N_ROW_PAIRS][N_COLUMNS][N_PLANES];
  bit              loaded    [N_ROW_PAIRS][N_COLUMNS][N_PLANES];
  int unsigned     row_cnt   = 0;
  int unsigned     plane_cnt = N_PLANES - RESET_PLANES_IN_USE;
  int unsigned     col_cnt   = 0;
  phase_e          scan_ph   = PH_ROW;
  longint unsigned lit_cnt   = 0;
  out_res_t        pins_q    = '{3'd0, 3'd0, 1'b0, 1'b0, 1'b1, 4'd0};

  led_matrix_bcm_scan_driver_top #(
    .MAX_PLANES   (N_PLANES),
    .MAX_COLUMNS  (N_COLUMNS),
    .MAX_ROW_PAIRS(N_ROW_PAIRS),
    .PLANE_OFFSET (0)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned limit_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned first_shown_plane();
    return N_PLANES - limit_to(cfg_q.planes_in_use, N_PLANES);
  endfunction

  function automatic in_req_t make_request(logic cmd, int unsigned row, int unsigned col,
                                           int unsigned plane, int unsigned colour);
    in_req_t req;
    req.cmd         = cmd;
    req.row_pair    = 4'(row);
    req.column      = 6'(col);
    req.plane       = 4'(plane);
    req.colour_bits = 6'(colour);
    return req;
  endfunction

  function automatic in_req_t random_request(bit wr);
    return make_request(wr ? CMD_WRITE : CMD_TICK, $urandom_range(0, 15),
                        $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 63));
  endfunction

  task automatic advance_scan();
    longint unsigned lit_len;
    case (scan_ph)
      PH_ROW: begin
        pins_q.row_select = 4'(row_cnt);
        plane_cnt = first_shown_plane();
        col_cnt = 0;
        scan_ph = PH_DATA;
      end
      PH_DATA: begin
        pins_q.shift_clock = 1'b0;
        if (col_cnt < N_COLUMNS && plane_cnt < N_PLANES) begin
          {pins_q.lower_rgb, pins_q.upper_rgb} = plane_mem[row_cnt][col_cnt][plane_cnt];
        end else begin
          {pins_q.lower_rgb, pins_q.upper_rgb} = 6'd0;
        end
        scan_ph = PH_CLKHI;
      end
      PH_CLKHI: begin
        pins_q.shift_clock = 1'b1;
        col_cnt++;
        scan_ph = (col_cnt >= limit_to(cfg_q.columns_in_use, N_COLUMNS)) ? PH_CLEAR : PH_DATA;
      end
      PH_CLEAR: begin
        pins_q.upper_rgb = 3'd0;
        pins_q.lower_rgb = 3'd0;
        pins_q.shift_clock = 1'b0;
        scan_ph = PH_LATCH_HI;
      end
      PH_LATCH_HI: begin
        pins_q.latch = 1'b1;
        scan_ph = PH_LATCH_LO;
      end
      PH_LATCH_LO: begin
        pins_q.latch = 1'b0;
        lit_cnt = 0;
        scan_ph = PH_LIT;
      end
      PH_LIT: begin
        pins_q.output_enable_n = 1'b0;
        lit_cnt++;
        lit_len = (cfg_q.base_ticks == '0) ? 1 : cfg_q.base_ticks;
        lit_len = lit_len << plane_cnt;
        if (lit_cnt >= lit_len) begin
          lit_cnt = 0;
          scan_ph = PH_DARK;
        end
      end
      default: begin
        pins_q.output_enable_n = 1'b1;
        plane_cnt++;
        if (plane_cnt < N_PLANES) begin
          col_cnt = 0;
          scan_ph = PH_DATA;
        end else begin
          row_cnt++;
          if (row_cnt >= limit_to(cfg_q.row_pairs_in_use, N_ROW_PAIRS)) row_cnt = 0;
          scan_ph = PH_ROW;
        end
      end
    endcase
  endtask

  task automatic take_request(in_req_t req);
    if (req.cmd == CMD_WRITE) begin
      if (req.plane < N_PLANES) begin
        plane_mem[req.row_pair][req.column][req.plane] = req.colour_bits;
      end
    end else begin
      if (cfg_q.run_enable) advance_scan();
      pins_due.push_back(pins_q);
    end
  endtask

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_pins(out_res_t got);
    out_res_t want;
    if (pins_due.size() == 0) begin
      $error("pin state %h arrived with no tick waiting", got);
      errors++;
      return;
    end
    want = pins_due.pop_front();
    check_field("upper_rgb", want.upper_rgb, got.upper_rgb);
    check_field("lower_rgb", want.lower_rgb, got.lower_rgb);
    check_field("shift_clock", want.shift_clock, got.shift_clock);
    check_field("latch", want.latch, got.latch);
    check_field("output_enable_n", want.output_enable_n, got.output_enable_n);
    check_field("row_select", want.row_select, got.row_select);
  endtask

  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) check_pins(out_res_o);
    if (rst_ni && in_valid_i && !in_stall_o) take_request(in_req_i);
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (pending.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_req_i <= pending.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic queue_request(in_req_t req);
    if (req.cmd == CMD_WRITE && req.plane < N_PLANES) begin
      loaded[req.row_pair][req.column][req.plane] = 1'b1;
    end
    pending.push_back(req);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_RUN_ENABLE:       cfg_q.run_enable = val[0];
      REG_BASE_TICKS:       cfg_q.base_ticks = val[15:0];
      REG_PLANES_IN_USE:    cfg_q.planes_in_use = val[3:0];
      REG_COLUMNS_IN_USE:   cfg_q.columns_in_use = val[6:0];
      REG_ROW_PAIRS_IN_USE: cfg_q.row_pairs_in_use = val[4:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || in_valid_i || pins_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes every store entry in the given box that has never been written.
  task automatic preload_box(int unsigned r_lo, int unsigned r_hi, int unsigned c_hi,
                             int unsigned p_lo);
    for (int unsigned r = r_lo; r < r_hi; r++) begin
      for (int unsigned c = 0; c < c_hi; c++) begin
        for (int unsigned p = p_lo; p < N_PLANES; p++) begin
          if (!loaded[r][c][p]) begin
            queue_request(make_request(CMD_WRITE, r, c, p, $urandom_range(0, 63)));
          end
        end
      end
    end
  endtask

  task automatic run_phase(logic run, logic [15:0] base, logic [3:0] planes, logic [6:0] cols,
                           logic [4:0] rows, int unsigned items, bit calm, bit press);
    int unsigned n_rows;
    int unsigned n_cols;
    int unsigned lo;
    int unsigned cols_now;
    wait_idle();
    write_reg(REG_RUN_ENABLE, 32'(run));
    write_reg(REG_BASE_TICKS, 32'(base));
    write_reg(REG_PLANES_IN_USE, 32'(planes));
    write_reg(REG_COLUMNS_IN_USE, 32'(cols));
    write_reg(REG_ROW_PAIRS_IN_USE, 32'(rows));
    steady = calm;
    n_rows = limit_to(cfg_q.row_pairs_in_use, N_ROW_PAIRS);
    n_cols = limit_to(cfg_q.columns_in_use, N_COLUMNS);
    lo = first_shown_plane();
    // The scan may finish the row, plane and column it stopped in under the
    // old limits before the new ones take hold.
    preload_box(0, n_rows, n_cols, lo);
    cols_now = (col_cnt + 1 < N_COLUMNS) ? col_cnt + 1 : N_COLUMNS;
    preload_box(row_cnt, row_cnt + 1, (cols_now > n_cols) ? cols_now : n_cols,
                (plane_cnt < lo) ? plane_cnt : lo);
    repeat (items) queue_request(random_request($urandom_range(0, 99) < WRITE_PCT));
    if (press) holds_asked++;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_request(make_request(CMD_TICK, 0, 0, 0, 0));
    queue_request(make_request(CMD_WRITE, 15, 63, 10, 63));
    queue_request(make_request(CMD_WRITE, 0, 0, 0, 0));
    queue_request(make_request(CMD_WRITE, 9, 42, 15, 42));
    queue_request(make_request(CMD_WRITE, 6, 21, 11, 21));
    queue_request(make_request(CMD_WRITE, 0, 1, 0, 21));
    queue_request(make_request(CMD_WRITE, 1, 2, 5, 42));
    queue_request(make_request(CMD_TICK, 15, 63, 15, 63));

    run_phase(1'b1, 16'd1, 4'd11, 7'd4, 5'd2, 100, 1'b0, 1'b0);
    run_phase(1'b1, 16'd1, 4'd0, 7'd1, 5'd1, 100, 1'b0, 1'b0);
    run_phase(1'b1, 16'd1, 4'd1, 7'd127, 5'd1, 800, 1'b1, 1'b0);
    run_phase(1'b1, 16'd0, 4'd1, 7'd0, 5'd31, 80, 1'b0, 1'b0);
    run_phase(1'b0, 16'd5, 4'd6, 7'd3, 5'd3, 50, 1'b0, 1'b0);
    run_phase(1'b1, 16'hffff, 4'd12, 7'd2, 5'd2, 50, 1'b0, 1'b0);
    run_phase(1'b1, 16'd7, 4'd5, 7'd9, 5'd4, 200, 1'b0, 1'b1);
    repeat (4) begin
      run_phase($urandom_range(0, 9) != 0, 16'($urandom_range(0, 2)),
                4'($urandom_range(0, 15)), 7'($urandom_range(0, 12)),
                5'($urandom_range(0, 5)), 30, 1'b0, 1'b0);
    end
    wait_idle();

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
src/lmbcm_pkg.sv
src/lmbcm_ram.sv
src/lmbcm_cfg.sv
src/lmbcm_seq.sv
src/led_matrix_bcm_scan_driver_top.sv
tb/sv/led_matrix_bcm_scan_driver_top_tb.sv
